@@ rtl/core/gitrp_pkg.sv @@
`default_nettype none
package gitrp_pkg;

   localparam int CoordWidth = 40;
   localparam int TrigWidth  = 16;
   localparam int StepWidth  = 16;
   localparam int OrigWidth  = 16;
   localparam int CsrWidth   = 32;

   localparam logic [63:0]        ScaledMax = 64'h0000_00FF_FFFF_FFFF;
   localparam logic signed [63:0] CoordMax  = 64'sh0000_007F_FFFF_FFFF;
   localparam logic signed [63:0] CoordMin  = -64'sh0000_0080_0000_0000;

   typedef enum logic [2:0] {
      CSR_PLANE      = 3'd0,
      CSR_ROW_LENGTH = 3'd1,
      CSR_STEP_PAIR  = 3'd2,
      CSR_ROT_IN     = 3'd3,
      CSR_ROT_OUT    = 3'd4,
      CSR_ORIGIN_X   = 3'd5,
      CSR_ORIGIN_Y   = 3'd6,
      CSR_ORIGIN_Z   = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      PLANE_XY = 2'd0,
      PLANE_YZ = 2'd1,
      PLANE_ZX = 2'd2
   } plane_type;

   function automatic logic [CoordWidth-1:0] clamp_scaled(input logic [63:0] v);
      logic [63:0] c;
      c = (v > ScaledMax) ? ScaledMax : v;
      return c[CoordWidth-1:0];
   endfunction

   function automatic logic signed [CoordWidth-1:0] sat_coord(input logic signed [63:0] v);
      logic signed [63:0] c;
      if (v > CoordMax) begin
         c = CoordMax;
      end else if (v < CoordMin) begin
         c = CoordMin;
      end else begin
         c = v;
      end
      return c[CoordWidth-1:0];
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/gitrp_div_cell.sv @@
`default_nettype none
module gitrp_div_cell #(
   parameter int INDEX_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [15:0]           divisor,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [INDEX_BITS-1:0] in_rem,
   input  wire logic [INDEX_BITS-1:0] in_num,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [INDEX_BITS-1:0]      out_rem,
   output logic [INDEX_BITS-1:0]      out_num
);

   localparam int DivWidth = (INDEX_BITS > 16) ? INDEX_BITS : 16;

   logic                  valid_ff;
   logic [INDEX_BITS-1:0] rem_ff, rem_in;
   logic [INDEX_BITS-1:0] num_ff, num_in;
   logic [INDEX_BITS-1:0] trial;
   logic [DivWidth-1:0]   trial_ext, div_ext, diff;
   logic                  take;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial     = {in_rem[INDEX_BITS-2:0], in_num[INDEX_BITS-1]};
      trial_ext = DivWidth'(trial);
      div_ext   = DivWidth'(divisor);
      take      = (divisor != 16'd0) && (trial_ext >= div_ext);
      diff      = trial_ext - div_ext;
      rem_in    = take ? diff[INDEX_BITS-1:0] : trial;
      num_in    = {in_num[INDEX_BITS-2:0], take};
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_num   = num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/gitrp_rotate.sv @@
`default_nettype none
module gitrp_rotate #(
   parameter int INDEX_BITS     = 16,
   parameter int TRIG_FRAC_BITS = 14
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [1:0]                     plane,
   input  wire logic [31:0]                    step_pair,
   input  wire logic [31:0]                    rot_in,
   input  wire logic [31:0]                    rot_out,
   input  wire logic signed [15:0]             origin_x,
   input  wire logic signed [15:0]             origin_y,
   input  wire logic signed [15:0]             origin_z,
   input  wire logic                           in_valid,
   output logic                                in_ready,
   input  wire logic [INDEX_BITS-1:0]          col,
   input  wire logic [INDEX_BITS-1:0]          row,
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output logic [3*gitrp_pkg::CoordWidth-1:0]  out_data
);
   import gitrp_pkg::*;

   localparam int Stages   = 6;
   localparam int ProdW    = INDEX_BITS + StepWidth;
   localparam int RotProdW = CoordWidth + 1 + TrigWidth;
   localparam int TiltProdW = CoordWidth + TrigWidth;
   localparam logic signed [63:0] Half = 64'sd1 <<< (TRIG_FRAC_BITS - 1);

   logic [Stages-1:0] valid_ff, valid_in, go;

   logic [CoordWidth-1:0]        x1_ff, x1_in, y1_ff, y1_in;
   logic signed [RotProdW-1:0]   xc1_ff, xc1_in, ys1_ff, ys1_in;
   logic signed [RotProdW-1:0]   xs1_ff, xs1_in, yc1_ff, yc1_in;
   logic signed [CoordWidth-1:0] u3_ff, u3_in, v3_ff, v3_in;
   logic signed [CoordWidth-1:0] u4_ff;
   logic signed [TiltProdW-1:0]  vc2_ff, vc2_in, vs2_ff, vs2_in;
   logic signed [CoordWidth-1:0] rx5_ff, rx5_in, ry5_ff, ry5_in, rz5_ff, rz5_in;
   logic signed [CoordWidth-1:0] ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in;

   logic [ProdW-1:0]             prod_x, prod_y;
   logic signed [CoordWidth:0]   xs, ys;
   logic signed [TrigWidth-1:0]  c1, s1, c2, s2;
   logic signed [63:0]           sum_u, sum_v, t_vc2, t_vs2;
   logic signed [CoordWidth-1:0] vt, w;

   always_comb begin
      go[Stages-1] = !valid_ff[Stages-1] || out_ready;
      for (int k = Stages - 2; k >= 0; k--) begin
         go[k] = !valid_ff[k] || go[k+1];
      end
      valid_in[0] = in_valid;
      for (int k = 1; k < Stages; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   assign in_ready  = go[0];
   assign out_valid = valid_ff[Stages-1];
   assign out_data  = {oz_ff, oy_ff, ox_ff};

   always_comb begin
      c1 = signed'(rot_in[31:16]);
      s1 = signed'(rot_in[15:0]);
      c2 = signed'(rot_out[31:16]);
      s2 = signed'(rot_out[15:0]);

      // scale by the steps
      prod_x = ProdW'(col) * ProdW'(step_pair[15:0]);
      prod_y = ProdW'(row) * ProdW'(step_pair[31:16]);
      x1_in  = clamp_scaled(64'(prod_x));
      y1_in  = clamp_scaled(64'(prod_y));

      // in-plane products
      xs     = signed'({1'b0, x1_ff});
      ys     = signed'({1'b0, y1_ff});
      xc1_in = xs * c1;
      ys1_in = ys * s1;
      xs1_in = xs * s1;
      yc1_in = ys * c1;

      // in-plane sums, round half up
      sum_u = 64'(xc1_ff) - 64'(ys1_ff) + Half;
      sum_v = 64'(xs1_ff) + 64'(yc1_ff) + Half;
      u3_in = sat_coord(sum_u >>> TRIG_FRAC_BITS);
      v3_in = sat_coord(sum_v >>> TRIG_FRAC_BITS);

      // tilt products
      vc2_in = v3_ff * c2;
      vs2_in = v3_ff * s2;

      // tilt rounding and axis mapping
      t_vc2 = 64'(vc2_ff) + Half;
      t_vs2 = 64'(vs2_ff) + Half;
      vt    = sat_coord(t_vc2 >>> TRIG_FRAC_BITS);
      w     = sat_coord(t_vs2 >>> TRIG_FRAC_BITS);
      case (plane)
         PLANE_YZ: begin
            rx5_in = w;
            ry5_in = u4_ff;
            rz5_in = vt;
         end
         PLANE_ZX: begin
            rx5_in = vt;
            ry5_in = w;
            rz5_in = u4_ff;
         end
         default: begin
            rx5_in = u4_ff;
            ry5_in = vt;
            rz5_in = w;
         end
      endcase

      // integer origin
      ox_in = sat_coord(64'(rx5_ff) + 64'(signed'({origin_x, 8'd0})));
      oy_in = sat_coord(64'(ry5_ff) + 64'(signed'({origin_y, 8'd0})));
      oz_in = sat_coord(64'(rz5_ff) + 64'(signed'({origin_z, 8'd0})));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < Stages; k++) begin
            if (go[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go[0] && valid_in[0]) begin
         x1_ff <= x1_in;
         y1_ff <= y1_in;
      end
      if (go[1] && valid_in[1]) begin
         xc1_ff <= xc1_in;
         ys1_ff <= ys1_in;
         xs1_ff <= xs1_in;
         yc1_ff <= yc1_in;
      end
      if (go[2] && valid_in[2]) begin
         u3_ff <= u3_in;
         v3_ff <= v3_in;
      end
      if (go[3] && valid_in[3]) begin
         u4_ff  <= u3_ff;
         vc2_ff <= vc2_in;
         vs2_ff <= vs2_in;
      end
      if (go[4] && valid_in[4]) begin
         rx5_ff <= rx5_in;
         ry5_ff <= ry5_in;
         rz5_ff <= rz5_in;
      end
      if (go[5] && valid_in[5]) begin
         ox_ff <= ox_in;
         oy_ff <= oy_in;
         oz_ff <= oz_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/grid_index_to_rotated_point_core.sv @@
// grid point number to rotated 3d point
//
// req_ channel: one beat per grid point number, row-major from zero.
// rsp_ channel: one beat per point, coord_x, coord_y, coord_z as signed
// 40-bit fixed point with 8 fraction bits.
// csr_ channel: register writes by index, always ready; write only while
// no beat is in flight.
//
// the divider is a row of INDEX_BITS cells, one quotient bit each, followed
// by six arithmetic stages; throughput is one beat per cycle while rsp is not stalled.
// every stage holds a valid bit and fills bubbles on its own, so input keeps
// being taken while a result waits, until the whole row is full.
// reset empties the row and loads the default registers.
`default_nettype none
module grid_index_to_rotated_point_core #(
   parameter int INDEX_BITS     = 16,
   parameter int TRIG_FRAC_BITS = 14
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [15:0]                         req_tdata,  // point_index
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [3*gitrp_pkg::CoordWidth-1:0]       rsp_tdata,  // coord_x, coord_y, coord_z
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [2:0]                          csr_index,
   input  wire logic [gitrp_pkg::CsrWidth-1:0]      csr_data
);
   import gitrp_pkg::*;

   logic [1:0]         plane_ff;
   logic [15:0]        row_length_ff;
   logic [31:0]        step_pair_ff;
   logic [31:0]        rot_in_ff;
   logic [31:0]        rot_out_ff;
   logic signed [15:0] origin_x_ff, origin_y_ff, origin_z_ff;

   logic                  div_valid [INDEX_BITS+1];
   logic                  div_ready [INDEX_BITS+1];
   logic [INDEX_BITS-1:0] div_rem   [INDEX_BITS+1];
   logic [INDEX_BITS-1:0] div_num   [INDEX_BITS+1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff      <= 2'd0;
         row_length_ff <= 16'd11;
         step_pair_ff  <= 32'h0100_0100;
         rot_in_ff     <= 32'h4000_0000;
         rot_out_ff    <= 32'h4000_0000;
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         origin_z_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PLANE:      plane_ff      <= csr_data[1:0];
            CSR_ROW_LENGTH: row_length_ff <= csr_data[15:0];
            CSR_STEP_PAIR:  step_pair_ff  <= csr_data;
            CSR_ROT_IN:     rot_in_ff     <= csr_data;
            CSR_ROT_OUT:    rot_out_ff    <= csr_data;
            CSR_ORIGIN_X:   origin_x_ff   <= signed'(csr_data[15:0]);
            CSR_ORIGIN_Y:   origin_y_ff   <= signed'(csr_data[15:0]);
            CSR_ORIGIN_Z:   origin_z_ff   <= signed'(csr_data[15:0]);
            default: ;
         endcase
      end
   end

   assign div_valid[0] = req_tvalid;
   assign req_tready   = div_ready[0];
   assign div_rem[0]   = '0;
   assign div_num[0]   = INDEX_BITS'(req_tdata);

   for (genvar i = 0; i < INDEX_BITS; i++) begin : g_div
      gitrp_div_cell #(
         .INDEX_BITS(INDEX_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .divisor  (row_length_ff),
         .in_valid (div_valid[i]),
         .in_ready (div_ready[i]),
         .in_rem   (div_rem[i]),
         .in_num   (div_num[i]),
         .out_valid(div_valid[i+1]),
         .out_ready(div_ready[i+1]),
         .out_rem  (div_rem[i+1]),
         .out_num  (div_num[i+1])
      );
   end

   gitrp_rotate #(
      .INDEX_BITS    (INDEX_BITS),
      .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
   ) u_rotate (
      .clock    (clock),
      .reset    (reset),
      .plane    (plane_ff),
      .step_pair(step_pair_ff),
      .rot_in   (rot_in_ff),
      .rot_out  (rot_out_ff),
      .origin_x (origin_x_ff),
      .origin_y (origin_y_ff),
      .origin_z (origin_z_ff),
      .in_valid (div_valid[INDEX_BITS]),
      .in_ready (div_ready[INDEX_BITS]),
      .col      (div_rem[INDEX_BITS]),
      .row      (div_num[INDEX_BITS]),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data (rsp_tdata)
   );

endmodule
`default_nettype wire

@@ rtl/core/gitrp_checker.sv @@
`default_nettype none
module gitrp_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [119:0] rsp_tdata
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp beat right after reset");

   // an empty output stage means the whole row can take a beat
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req not ready while output is empty");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp data changed while stalled");

endmodule

bind grid_index_to_rotated_point_core gitrp_checker u_gitrp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
`default_nettype wire

@@ sim/tb_grid_index_to_rotated_point_core.sv @@
`default_nettype none
module tb_grid_index_to_rotated_point_core;
   timeunit 1ns;
   timeprecision 1ps;

   import gitrp_pkg::*;

   localparam int IndexBits    = 16;
   localparam int TrigFracBits = 14;
   localparam int RowCycles    = IndexBits + 6;
   localparam logic [1:0] PlaneUnused = 2'd3;

   typedef struct {
      logic [1:0]  plane;
      logic [15:0] row_length;
      logic [31:0] step_pair;
      logic [31:0] rot_in;
      logic [31:0] rot_out;
      logic [15:0] origin_x;
      logic [15:0] origin_y;
      logic [15:0] origin_z;
   } grid_cfg_type;

   typedef struct packed {
      logic [CoordWidth-1:0] z;
      logic [CoordWidth-1:0] y;
      logic [CoordWidth-1:0] x;
   } coord_set_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [15:0]             req_tdata  = '0;  // point_index
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [3*CoordWidth-1:0] rsp_tdata;        // coord_x, coord_y, coord_z
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [2:0]              csr_index  = '0;
   logic [CsrWidth-1:0]     csr_data   = '0;

   grid_cfg_type  active_cfg;
   coord_set_type pending_points[$];

   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   int hold_request    = 0;
   int hold_left       = 0;
   int failures        = 0;
   int points_checked  = 0;
   int settings_loaded = 0;

   grid_index_to_rotated_point_core #(
      .INDEX_BITS    (IndexBits),
      .TRIG_FRAC_BITS(TrigFracBits)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic longint clip40(input longint v);
      if (v > CoordMax) begin
         return CoordMax;
      end
      if (v < CoordMin) begin
         return CoordMin;
      end
      return v;
   endfunction

   // round half up back to 8 fraction bits
   function automatic longint round_trig(input longint v);
      return (v + (longint'(1) << (TrigFracBits - 1))) >>> TrigFracBits;
   endfunction

   function automatic coord_set_type rotate_grid_point(input logic [15:0] point_index);
      longint idx, col, row, sx, sy, c1, s1, c2, s2, u, v, vt, w, rx, ry, rz;
      coord_set_type p;
      idx = longint'(point_index) & ((longint'(1) << IndexBits) - 1);
      if (active_cfg.row_length == 0) begin
         col = idx;
         row = 0;
      end else begin
         col = idx % longint'(active_cfg.row_length);
         row = idx / longint'(active_cfg.row_length);
      end
      sx = col * longint'(active_cfg.step_pair[15:0]);
      sy = row * longint'(active_cfg.step_pair[31:16]);
      if (sx > longint'(ScaledMax)) begin
         sx = longint'(ScaledMax);
      end
      if (sy > longint'(ScaledMax)) begin
         sy = longint'(ScaledMax);
      end
      c1 = longint'($signed(active_cfg.rot_in[31:16]));
      s1 = longint'($signed(active_cfg.rot_in[15:0]));
      c2 = longint'($signed(active_cfg.rot_out[31:16]));
      s2 = longint'($signed(active_cfg.rot_out[15:0]));
      u  = clip40(round_trig(sx * c1 - sy * s1));
      v  = clip40(round_trig(sx * s1 + sy * c1));
      vt = clip40(round_trig(v * c2));
      w  = clip40(round_trig(v * s2));
      case (active_cfg.plane)
         PLANE_YZ: begin
            rx = w;
            ry = u;
            rz = vt;
         end
         PLANE_ZX: begin
            rx = vt;
            ry = w;
            rz = u;
         end
         default: begin
            rx = u;
            ry = vt;
            rz = w;
         end
      endcase
      rx  = clip40(rx + longint'($signed(active_cfg.origin_x)) * 256);
      ry  = clip40(ry + longint'($signed(active_cfg.origin_y)) * 256);
      rz  = clip40(rz + longint'($signed(active_cfg.origin_z)) * 256);
      p.x = rx[CoordWidth-1:0];
      p.y = ry[CoordWidth-1:0];
      p.z = rz[CoordWidth-1:0];
      return p;
   endfunction

   function automatic grid_cfg_type random_cfg();
      grid_cfg_type c;
      c.plane = 2'($urandom_range(3));
      case ($urandom_range(9))
         0: c.row_length = 16'd0;
         1: c.row_length = 16'hFFFF;
         2: c.row_length = 16'($urandom);
         default: c.row_length = 16'($urandom_range(40, 1));
      endcase
      c.step_pair = $urandom;
      c.rot_in    = ($urandom_range(3) == 0) ? 32'h4000_0000 : $urandom;
      c.rot_out   = ($urandom_range(3) == 0) ? 32'h4000_0000 : $urandom;
      c.origin_x  = 16'($urandom);
      c.origin_y  = 16'($urandom);
      c.origin_z  = 16'($urandom);
      return c;
   endfunction

   function automatic logic [15:0] random_index();
      if ($urandom_range(1) == 0) begin
         return 16'($urandom);
      end
      return 16'($urandom_range(300));
   endfunction

   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PLANE:      active_cfg.plane      = value[1:0];
         CSR_ROW_LENGTH: active_cfg.row_length = value[15:0];
         CSR_STEP_PAIR:  active_cfg.step_pair  = value;
         CSR_ROT_IN:     active_cfg.rot_in     = value;
         CSR_ROT_OUT:    active_cfg.rot_out    = value;
         CSR_ORIGIN_X:   active_cfg.origin_x   = value[15:0];
         CSR_ORIGIN_Y:   active_cfg.origin_y   = value[15:0];
         CSR_ORIGIN_Z:   active_cfg.origin_z   = value[15:0];
         default: ;
      endcase
   endtask

   task automatic load_config(input grid_cfg_type c);
      write_csr(CSR_PLANE,      {30'd0, c.plane});
      write_csr(CSR_ROW_LENGTH, {16'd0, c.row_length});
      write_csr(CSR_STEP_PAIR,  c.step_pair);
      write_csr(CSR_ROT_IN,     c.rot_in);
      write_csr(CSR_ROT_OUT,    c.rot_out);
      write_csr(CSR_ORIGIN_X,   {16'd0, c.origin_x});
      write_csr(CSR_ORIGIN_Y,   {16'd0, c.origin_y});
      write_csr(CSR_ORIGIN_Z,   {16'd0, c.origin_z});
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   // valid stays high after a beat so back-to-back points need no gap
   task automatic send_point(input logic [15:0] point_index);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= point_index;
      do @(posedge clock); while (!req_tready);
      pending_points.push_back(rotate_grid_point(point_index));
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic test_default_registers();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_point(16'd0);
      send_point(16'd1);
      send_point(16'd10);
      send_point(16'd11);
      send_point(16'd12);
      send_point(16'hFFFF);
      wait_for_results();
   endtask

   task automatic test_corner_settings();
      grid_cfg_type c;
      // zero row length, full steps, most negative and most positive trig values
      c = '{plane: PLANE_YZ, row_length: 16'd0, step_pair: 32'hFFFF_FFFF,
            rot_in: 32'h8000_7FFF, rot_out: 32'h7FFF_8000,
            origin_x: 16'h7FFF, origin_y: 16'h8000, origin_z: 16'h7FFF};
      load_config(c);
      send_point(16'hFFFF);
      send_point(16'h5555);
      send_point(16'h0000);
      wait_for_results();
      c = '{plane: PLANE_ZX, row_length: 16'd1, step_pair: 32'h0000_0000,
            rot_in: 32'h7FFF_8000, rot_out: 32'h8000_7FFF,
            origin_x: 16'h8000, origin_y: 16'h7FFF, origin_z: 16'h8000};
      load_config(c);
      send_point(16'hFFFF);
      send_point(16'hAAAA);
      wait_for_results();
      // unused plane code behaves as xy
      c = '{plane: PlaneUnused, row_length: 16'hFFFF, step_pair: 32'hFFFF_0001,
            rot_in: 32'h8000_8000, rot_out: 32'h0000_FFFF,
            origin_x: 16'hFFFF, origin_y: 16'h0001, origin_z: 16'h0000};
      load_config(c);
      send_point(16'hFFFE);
      send_point(16'hFFFF);
      send_point(16'h0000);
      wait_for_results();
      c = '{plane: PLANE_XY, row_length: 16'd2, step_pair: 32'h0180_0040,
            rot_in: 32'h2D41_2D41, rot_out: 32'h3800_E000,
            origin_x: 16'h0005, origin_y: 16'hFFFB, origin_z: 16'h0100};
      load_config(c);
      send_point(16'd1);
      send_point(16'd2);
      send_point(16'd3);
      send_point(16'd7);
      wait_for_results();
      c = '{plane: PLANE_YZ, row_length: 16'd7, step_pair: 32'h0100_0100,
            rot_in: 32'h0000_4000, rot_out: 32'h0000_4000,
            origin_x: 16'h0000, origin_y: 16'h0000, origin_z: 16'h0000};
      load_config(c);
      send_point(16'd6);
      send_point(16'd7);
      send_point(16'd8);
      wait_for_results();
   endtask

   task automatic test_random_settings();
      int idle_mix[4]  = '{0, 62, 0, 30};
      int stall_mix[4] = '{0, 0, 62, 30};
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = idle_mix[phase];
         recv_stall_pct = stall_mix[phase];
         for (int chunk = 0; chunk < 4; chunk++) begin
            load_config(random_cfg());
            for (int i = 0; i < 42; i++) begin
               send_point(random_index());
            end
            wait_for_results();
         end
      end
   endtask

   // receiver holds off long enough for the pipeline to fill and stall input
   task automatic test_output_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      load_config(random_cfg());
      hold_request = 150;
      for (int i = 0; i < 80; i++) begin
         send_point(random_index());
      end
      wait_for_results();
   endtask

   task automatic test_input_pause();
      send_idle_pct  = 0;
      recv_stall_pct = 30;
      for (int i = 0; i < 20; i++) begin
         send_point(random_index());
      end
      wait_for_results();
      for (int i = 0; i < 20; i++) begin
         send_point(random_index());
      end
      wait_for_results();
   endtask

   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : check_points
      coord_set_type got;
      coord_set_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_points.size() == 0) begin
            $error("result beat with nothing pending: x=%0d y=%0d z=%0d",
                   $signed(got.x), $signed(got.y), $signed(got.z));
            failures++;
         end else begin
            want = pending_points.pop_front();
            if (got.x !== want.x) begin
               $error("coord_x: expected %0d, got %0d", $signed(want.x), $signed(got.x));
               failures++;
            end
            if (got.y !== want.y) begin
               $error("coord_y: expected %0d, got %0d", $signed(want.y), $signed(got.y));
               failures++;
            end
            if (got.z !== want.z) begin
               $error("coord_z: expected %0d, got %0d", $signed(want.z), $signed(got.z));
               failures++;
            end
            points_checked++;
         end
      end
   end

   initial begin
      active_cfg = '{plane: PLANE_XY, row_length: 16'd11, step_pair: 32'h0100_0100,
                     rot_in: 32'h4000_0000, rot_out: 32'h4000_0000,
                     origin_x: 16'h0000, origin_y: 16'h0000, origin_z: 16'h0000};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_registers();
      test_corner_settings();
      test_random_settings();
      test_output_backpressure();
      test_input_pause();
      wait_for_results();
      repeat (RowCycles + 10) @(posedge clock);
      $display("run covered %0d grid points over %0d register settings,",
               points_checked, settings_loaded);
      $display("all plane codes, zero and full row lengths, output hold-off and idle mixes");
      if (failures == 0 && pending_points.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
`default_nettype wire
